// ----- sv/css_mrk_pkg.sv -----
`default_nettype none

package css_mrk_pkg;

    // Input item: one text byte or an end-of-text flush
    typedef struct packed {
        logic       op;
        logic [7:0] byte_value;
    } item_t;

    // Result item: a literal byte or a style mark
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [2:0] style;
        logic       last;
    } result_t;

    localparam int unsigned MAX_RESULTS = 4;

    // Result burst for one item, plus the scan state it leaves behind
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [2:0]                count;
        logic [3:0]                state;
        logic [1:0]                ctx;
    } burst_t;

    // Item opcodes
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result kinds
    localparam logic KIND_LIT  = 1'b0;
    localparam logic KIND_MARK = 1'b1;

    // Style codes
    localparam logic [2:0] STY_RESET    = 3'd0;
    localparam logic [2:0] STY_SELECTOR = 3'd1;
    localparam logic [2:0] STY_PROPERTY = 3'd2;
    localparam logic [2:0] STY_STRING   = 3'd3;
    localparam logic [2:0] STY_COMMENT  = 3'd4;

    // Scan states
    localparam logic [3:0] ST_NORMAL       = 4'd0;
    localparam logic [3:0] ST_SELECTOR     = 4'd1;
    localparam logic [3:0] ST_PROPERTY     = 4'd2;
    localparam logic [3:0] ST_VALUE        = 4'd3;
    localparam logic [3:0] ST_QUOTE        = 4'd4;
    localparam logic [3:0] ST_QUOTE_ESC    = 4'd5;
    localparam logic [3:0] ST_DQUOTE       = 4'd6;
    localparam logic [3:0] ST_DQUOTE_ESC   = 4'd7;
    localparam logic [3:0] ST_SLASH        = 4'd8;
    localparam logic [3:0] ST_COMMENT      = 4'd9;
    localparam logic [3:0] ST_COMMENT_STAR = 4'd10;

    // Return context codes (regions only)
    localparam logic [1:0] CTX_SELECTOR = 2'd1;
    localparam logic [1:0] CTX_PROPERTY = 2'd2;
    localparam logic [1:0] CTX_VALUE    = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    function automatic result_t lit_item(input logic [7:0] b);
        result_t r;
        r.kind     = KIND_LIT;
        r.out_byte = b;
        r.style    = STY_RESET;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic result_t mark_item(input logic [2:0] sty);
        result_t r;
        r.kind     = KIND_MARK;
        r.out_byte = 8'h00;
        r.style    = sty;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/css_mrk_scan.sv -----
`default_nettype none

// Next-state and result burst for one item, all combinational
module css_mrk_scan (
    input  wire css_mrk_pkg::item_t item,
    input  wire logic [3:0]         state,
    input  wire logic [1:0]         ctx,
    output css_mrk_pkg::burst_t     step
);

    css_mrk_pkg::result_t [css_mrk_pkg::MAX_RESULTS-1:0] res;
    logic [2:0] n;
    logic [1:0] last_idx;
    logic [3:0] st;
    logic [1:0] cx;
    logic [3:0] r;
    logic [1:0] sv;
    logic [7:0] c;
    logic       do_region;
    logic       do_close;

    always_comb
    begin
        res       = '0;
        n         = 3'd0;
        st        = state;
        cx        = ctx;
        r         = css_mrk_pkg::ST_SELECTOR;
        c         = item.byte_value;
        do_region = 1'b0;
        do_close  = 1'b0;
        last_idx  = 2'd0;
        // saved region; the unused context code counts as selector
        sv = (ctx == 2'd0) ? css_mrk_pkg::CTX_SELECTOR : ctx;

        if (item.op == css_mrk_pkg::OP_END)
        begin
            // flush
            case (state)
                css_mrk_pkg::ST_SLASH:
                begin
                    res[n[1:0]] = css_mrk_pkg::lit_item(css_mrk_pkg::CH_SLASH);
                    n = n + 3'd1;
                end
                css_mrk_pkg::ST_SELECTOR, css_mrk_pkg::ST_PROPERTY,
                css_mrk_pkg::ST_DQUOTE, css_mrk_pkg::ST_DQUOTE_ESC:
                begin
                    res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
                    n = n + 3'd1;
                end
                default:
                begin
                end
            endcase
            res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
            n  = n + 3'd1;
            st = css_mrk_pkg::ST_NORMAL;
            cx = css_mrk_pkg::CTX_SELECTOR;
        end
        else
        begin
            case (state)
                css_mrk_pkg::ST_SELECTOR, css_mrk_pkg::ST_PROPERTY,
                css_mrk_pkg::ST_VALUE:
                begin
                    do_region = 1'b1;
                    r         = state;
                end
                css_mrk_pkg::ST_SLASH:
                begin
                    if (c == css_mrk_pkg::CH_STAR)
                    begin
                        res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_COMMENT);
                        n = n + 3'd1;
                        res[n[1:0]] = css_mrk_pkg::lit_item(css_mrk_pkg::CH_SLASH);
                        n = n + 3'd1;
                        res[n[1:0]] = css_mrk_pkg::lit_item(css_mrk_pkg::CH_STAR);
                        n  = n + 3'd1;
                        st = css_mrk_pkg::ST_COMMENT;
                    end
                    else
                    begin
                        // replay the held slash, then handle the byte
                        res[n[1:0]] = css_mrk_pkg::lit_item(css_mrk_pkg::CH_SLASH);
                        n         = n + 3'd1;
                        do_region = 1'b1;
                        r         = {2'b00, sv};
                    end
                end
                css_mrk_pkg::ST_COMMENT:
                begin
                    res[n[1:0]] = css_mrk_pkg::lit_item(c);
                    n = n + 3'd1;
                    if (c == css_mrk_pkg::CH_STAR)
                        st = css_mrk_pkg::ST_COMMENT_STAR;
                end
                css_mrk_pkg::ST_COMMENT_STAR:
                begin
                    res[n[1:0]] = css_mrk_pkg::lit_item(c);
                    n = n + 3'd1;
                    if (c == css_mrk_pkg::CH_SLASH)
                        do_close = 1'b1;
                    else if (c != css_mrk_pkg::CH_STAR)
                        st = css_mrk_pkg::ST_COMMENT;
                end
                css_mrk_pkg::ST_QUOTE, css_mrk_pkg::ST_DQUOTE:
                begin
                    res[n[1:0]] = css_mrk_pkg::lit_item(c);
                    n = n + 3'd1;
                    if (c == ((state == css_mrk_pkg::ST_QUOTE) ?
                              css_mrk_pkg::CH_QUOTE : css_mrk_pkg::CH_DQUOTE))
                        do_close = 1'b1;
                    else if (c == css_mrk_pkg::CH_BSLASH)
                        st = state + 4'd1;
                end
                css_mrk_pkg::ST_QUOTE_ESC, css_mrk_pkg::ST_DQUOTE_ESC:
                begin
                    res[n[1:0]] = css_mrk_pkg::lit_item(c);
                    n  = n + 3'd1;
                    st = state - 4'd1;
                end
                default:
                begin
                    // start of text (and unused codes)
                    res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_SELECTOR);
                    n         = n + 3'd1;
                    do_region = 1'b1;
                    r         = css_mrk_pkg::ST_SELECTOR;
                end
            endcase

            // leaving a string or comment
            if (do_close)
            begin
                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
                n  = n + 3'd1;
                st = {2'b00, sv};
                if (sv == css_mrk_pkg::CTX_SELECTOR)
                begin
                    res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_SELECTOR);
                    n = n + 3'd1;
                end
                else if (sv == css_mrk_pkg::CTX_PROPERTY)
                begin
                    res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_PROPERTY);
                    n = n + 3'd1;
                end
            end

            // byte in selector, property or value region
            if (do_region)
            begin
                st = r;
                if (c == css_mrk_pkg::CH_SLASH)
                begin
                    cx = r[1:0];
                    st = css_mrk_pkg::ST_SLASH;
                end
                else if (c == css_mrk_pkg::CH_QUOTE || c == css_mrk_pkg::CH_DQUOTE)
                begin
                    cx = r[1:0];
                    st = (c == css_mrk_pkg::CH_QUOTE) ?
                         css_mrk_pkg::ST_QUOTE : css_mrk_pkg::ST_DQUOTE;
                    res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_STRING);
                    n = n + 3'd1;
                    res[n[1:0]] = css_mrk_pkg::lit_item(c);
                    n = n + 3'd1;
                end
                else
                begin
                    case (r)
                        css_mrk_pkg::ST_SELECTOR:
                        begin
                            if (c == css_mrk_pkg::CH_LBRACE)
                            begin
                                st = css_mrk_pkg::ST_PROPERTY;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_PROPERTY);
                                n = n + 3'd1;
                            end
                            else if (c == css_mrk_pkg::CH_COMMA)
                            begin
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_SELECTOR);
                                n = n + 3'd1;
                            end
                            else
                            begin
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                            end
                        end
                        css_mrk_pkg::ST_PROPERTY:
                        begin
                            if (c == css_mrk_pkg::CH_COLON)
                            begin
                                st = css_mrk_pkg::ST_VALUE;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                            end
                            else if (c == css_mrk_pkg::CH_RBRACE)
                            begin
                                st = css_mrk_pkg::ST_SELECTOR;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_RESET);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_SELECTOR);
                                n = n + 3'd1;
                            end
                            else
                            begin
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                            end
                        end
                        default:
                        begin
                            // value region
                            if (c == css_mrk_pkg::CH_SEMI)
                            begin
                                st = css_mrk_pkg::ST_PROPERTY;
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_PROPERTY);
                                n = n + 3'd1;
                            end
                            else if (c == css_mrk_pkg::CH_RBRACE)
                            begin
                                st = css_mrk_pkg::ST_SELECTOR;
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                                res[n[1:0]] = css_mrk_pkg::mark_item(css_mrk_pkg::STY_SELECTOR);
                                n = n + 3'd1;
                            end
                            else
                            begin
                                res[n[1:0]] = css_mrk_pkg::lit_item(c);
                                n = n + 3'd1;
                            end
                        end
                    endcase
                end
            end
        end

        // flag the final result of the burst (count 4 wraps to index 3)
        if (n != 3'd0)
        begin
            last_idx = n[1:0] - 2'd1;
            res[last_idx].last = 1'b1;
        end

        step.res   = res;
        step.count = n;
        step.state = st;
        step.ctx   = cx;
    end

endmodule

`default_nettype wire

// ----- sv/css_syntax_marker.sv -----
// An accepted item is held in the input register; its burst is loaded into the result
// register once that register is empty or its last result is being taken.
// Throughput: 1 item per cycle while items yield at most one result and no result is
// stalled; an item with more results holds the single result port until all of its
// results (up to 4) are taken.
// Reset: scan state to start of text, saved context to selector, both registers empty.
`default_nettype none

module css_syntax_marker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire css_mrk_pkg::item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output css_mrk_pkg::result_t      result
);

    css_mrk_pkg::item_t   item_reg;
    logic                 item_vld_reg;
    logic                 item_vld_next;
    logic [3:0]           state_reg;
    logic [3:0]           state_next;
    logic [1:0]           ctx_reg;
    logic [1:0]           ctx_next;
    css_mrk_pkg::result_t [css_mrk_pkg::MAX_RESULTS-1:0] res_reg;
    css_mrk_pkg::result_t [css_mrk_pkg::MAX_RESULTS-1:0] res_next;
    logic [2:0]           cnt_reg;
    logic [2:0]           cnt_next;
    css_mrk_pkg::burst_t  step;
    logic                 out_take;
    logic                 burst_free;
    logic                 load;
    logic                 item_take;

    css_mrk_scan u_scan (
        .item  (item_reg),
        .state (state_reg),
        .ctx   (ctx_reg),
        .step  (step)
    );

    // handshake
    assign result_valid = (cnt_reg != 3'd0);
    assign result       = res_reg[0];
    assign out_take     = result_valid && !result_stall;
    assign burst_free   = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_take);
    assign load         = item_vld_reg && burst_free;
    assign item_stall   = item_vld_reg && !burst_free;
    assign item_take    = item_valid && !item_stall;

    // next values
    always_comb
    begin
        item_vld_next = item_take || (item_vld_reg && !load);
        state_next    = load ? step.state : state_reg;
        ctx_next      = load ? step.ctx : ctx_reg;
        res_next      = res_reg;
        cnt_next      = cnt_reg;
        if (load)
        begin
            res_next = step.res;
            cnt_next = step.count;
        end
        else if (out_take)
        begin
            for (int i = 0; i < css_mrk_pkg::MAX_RESULTS - 1; i++)
                res_next[i] = res_reg[i+1];
            cnt_next = cnt_reg - 3'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            state_reg    <= css_mrk_pkg::ST_NORMAL;
            ctx_reg      <= css_mrk_pkg::CTX_SELECTOR;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            state_reg    <= state_next;
            ctx_reg      <= ctx_next;
            cnt_reg      <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- sv/css_mrk_checker.sv -----
`default_nettype none

module css_mrk_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_stall,
    input wire css_mrk_pkg::item_t   item,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire css_mrk_pkg::result_t result
);

    logic       take;
    logic [1:0] run_reg;
    logic       open_reg;
    logic       open_cmt_reg;

    assign take = result_valid && !result_stall;

    // results since the last final flag, and an opening mark awaiting its byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 2'd0;
            open_reg     <= 1'b0;
            open_cmt_reg <= 1'b0;
        end
        else if (take)
        begin
            run_reg      <= result.last ? 2'd0 : run_reg + 2'd1;
            open_reg     <= (result.kind == css_mrk_pkg::KIND_MARK) &&
                            (result.style == css_mrk_pkg::STY_STRING ||
                             result.style == css_mrk_pkg::STY_COMMENT);
            open_cmt_reg <= (result.style == css_mrk_pkg::STY_COMMENT);
        end
    end

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input item changed");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
        take && !result.last |-> run_reg != 2'd3)
        else $error("more than four results for one item");

    a_open_byte: assert property (@(posedge clk) disable iff (!rst_n)
        take && open_reg |-> result.kind == css_mrk_pkg::KIND_LIT &&
            (open_cmt_reg ? result.out_byte == css_mrk_pkg::CH_SLASH :
             (result.out_byte == css_mrk_pkg::CH_QUOTE ||
              result.out_byte == css_mrk_pkg::CH_DQUOTE)))
        else $error("string or comment mark not followed by its opening byte");

endmodule

bind css_syntax_marker css_mrk_checker u_css_mrk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// ----- dv/tb_css_syntax_marker.sv -----
`timescale 1ns / 1ps

module tb_css_syntax_marker;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 270;
    localparam int TAIL_CYCLES   = 20;
    localparam int MAX_PRINTS    = 100;

    // Text item waiting to be sent; drain holds it back until all marks are out
    typedef struct packed {
        css_mrk_pkg::item_t it;
        logic               drain;
    } text_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    css_mrk_pkg::item_t   item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    css_mrk_pkg::result_t result;

    text_item_t           text_q[$];
    css_mrk_pkg::result_t marks_due[$];
    css_mrk_pkg::result_t burst_q[$];

    // Scanner shadow state
    logic [3:0] scan_q = css_mrk_pkg::ST_NORMAL;
    logic [1:0] ctx_q  = css_mrk_pkg::CTX_SELECTOR;

    int  n_errors = 0;
    int  cycle_cnt = 0;
    bit  item_taken = 1'b0;
    bit  result_taken = 1'b0;
    bit  drain_mark = 1'b0;

    int  tx_gap = 0;
    int  tx_count = 0;
    bit  tx_calm = 1'b1;
    int  rx_gap = 0;
    int  rx_count = 0;
    bit  rx_calm = 1'b1;

    css_syntax_marker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner prediction
    // ------------------------------------------------------------------
    function automatic void push_res(logic k, logic [7:0] b, logic [2:0] sty);
        css_mrk_pkg::result_t r;
        if (burst_q.size() >= css_mrk_pkg::MAX_RESULTS)
            return;
        r.kind     = k;
        r.out_byte = b;
        r.style    = sty;
        r.last     = 1'b0;
        burst_q.push_back(r);
    endfunction

    function automatic void push_lit(logic [7:0] b);
        push_res(css_mrk_pkg::KIND_LIT, b, css_mrk_pkg::STY_RESET);
    endfunction

    function automatic void push_mark(logic [2:0] sty);
        push_res(css_mrk_pkg::KIND_MARK, 8'h00, sty);
    endfunction

    function automatic logic [3:0] home_region();
        return (ctx_q == 2'd0) ? css_mrk_pkg::ST_SELECTOR : {2'b00, ctx_q};
    endfunction

    // Closing quote or comment: reset, then reopen the saved region's style
    function automatic void leave_nested();
        logic [3:0] r;
        r = home_region();
        push_mark(css_mrk_pkg::STY_RESET);
        scan_q = r;
        if (r == css_mrk_pkg::ST_SELECTOR)
            push_mark(css_mrk_pkg::STY_SELECTOR);
        else if (r == css_mrk_pkg::ST_PROPERTY)
            push_mark(css_mrk_pkg::STY_PROPERTY);
    endfunction

    // Byte seen in selector, property or value region
    function automatic void region_byte(logic [7:0] c);
        logic [3:0] r;
        r = scan_q;
        if (c == css_mrk_pkg::CH_SLASH)
        begin
            ctx_q  = r[1:0];
            scan_q = css_mrk_pkg::ST_SLASH;
        end
        else if (c == css_mrk_pkg::CH_QUOTE || c == css_mrk_pkg::CH_DQUOTE)
        begin
            ctx_q  = r[1:0];
            scan_q = (c == css_mrk_pkg::CH_QUOTE) ?
                     css_mrk_pkg::ST_QUOTE : css_mrk_pkg::ST_DQUOTE;
            push_mark(css_mrk_pkg::STY_STRING);
            push_lit(c);
        end
        else if (r == css_mrk_pkg::ST_SELECTOR)
        begin
            if (c == css_mrk_pkg::CH_LBRACE)
            begin
                scan_q = css_mrk_pkg::ST_PROPERTY;
                push_mark(css_mrk_pkg::STY_RESET);
                push_lit(c);
                push_mark(css_mrk_pkg::STY_PROPERTY);
            end
            else if (c == css_mrk_pkg::CH_COMMA)
            begin
                push_mark(css_mrk_pkg::STY_RESET);
                push_lit(c);
                push_mark(css_mrk_pkg::STY_SELECTOR);
            end
            else
                push_lit(c);
        end
        else if (r == css_mrk_pkg::ST_PROPERTY)
        begin
            if (c == css_mrk_pkg::CH_COLON)
            begin
                scan_q = css_mrk_pkg::ST_VALUE;
                push_mark(css_mrk_pkg::STY_RESET);
                push_lit(c);
            end
            else if (c == css_mrk_pkg::CH_RBRACE)
            begin
                scan_q = css_mrk_pkg::ST_SELECTOR;
                push_mark(css_mrk_pkg::STY_RESET);
                push_lit(c);
                push_mark(css_mrk_pkg::STY_SELECTOR);
            end
            else
                push_lit(c);
        end
        else
        begin
            if (c == css_mrk_pkg::CH_SEMI)
            begin
                scan_q = css_mrk_pkg::ST_PROPERTY;
                push_lit(c);
                push_mark(css_mrk_pkg::STY_PROPERTY);
            end
            else if (c == css_mrk_pkg::CH_RBRACE)
            begin
                scan_q = css_mrk_pkg::ST_SELECTOR;
                push_lit(c);
                push_mark(css_mrk_pkg::STY_SELECTOR);
            end
            else
                push_lit(c);
        end
    endfunction

    function automatic void text_byte(logic [7:0] c);
        case (scan_q)
            css_mrk_pkg::ST_SELECTOR, css_mrk_pkg::ST_PROPERTY, css_mrk_pkg::ST_VALUE:
                region_byte(c);
            css_mrk_pkg::ST_SLASH:
            begin
                if (c == css_mrk_pkg::CH_STAR)
                begin
                    push_mark(css_mrk_pkg::STY_COMMENT);
                    push_lit(css_mrk_pkg::CH_SLASH);
                    push_lit(css_mrk_pkg::CH_STAR);
                    scan_q = css_mrk_pkg::ST_COMMENT;
                end
                else
                begin
                    // lone slash is replayed, then the byte goes to the region
                    push_lit(css_mrk_pkg::CH_SLASH);
                    scan_q = home_region();
                    region_byte(c);
                end
            end
            css_mrk_pkg::ST_COMMENT:
            begin
                push_lit(c);
                if (c == css_mrk_pkg::CH_STAR)
                    scan_q = css_mrk_pkg::ST_COMMENT_STAR;
            end
            css_mrk_pkg::ST_COMMENT_STAR:
            begin
                push_lit(c);
                if (c == css_mrk_pkg::CH_SLASH)
                    leave_nested();
                else if (c != css_mrk_pkg::CH_STAR)
                    scan_q = css_mrk_pkg::ST_COMMENT;
            end
            css_mrk_pkg::ST_QUOTE, css_mrk_pkg::ST_DQUOTE:
            begin
                push_lit(c);
                if (c == ((scan_q == css_mrk_pkg::ST_QUOTE) ?
                          css_mrk_pkg::CH_QUOTE : css_mrk_pkg::CH_DQUOTE))
                    leave_nested();
                else if (c == css_mrk_pkg::CH_BSLASH)
                    scan_q = scan_q + 4'd1;
            end
            css_mrk_pkg::ST_QUOTE_ESC, css_mrk_pkg::ST_DQUOTE_ESC:
            begin
                push_lit(c);
                scan_q = scan_q - 4'd1;
            end
            default:
            begin
                // start of text opens a selector
                push_mark(css_mrk_pkg::STY_SELECTOR);
                scan_q = css_mrk_pkg::ST_SELECTOR;
                region_byte(c);
            end
        endcase
    endfunction

    function automatic void end_of_text();
        case (scan_q)
            css_mrk_pkg::ST_SLASH:
                push_lit(css_mrk_pkg::CH_SLASH);
            css_mrk_pkg::ST_SELECTOR, css_mrk_pkg::ST_PROPERTY,
            css_mrk_pkg::ST_DQUOTE, css_mrk_pkg::ST_DQUOTE_ESC:
                push_mark(css_mrk_pkg::STY_RESET);
            default:
                ;
        endcase
        push_mark(css_mrk_pkg::STY_RESET);
        scan_q = css_mrk_pkg::ST_NORMAL;
        ctx_q  = css_mrk_pkg::CTX_SELECTOR;
    endfunction

    // Predict the marks for one accepted item and queue them
    function automatic void scan_item(css_mrk_pkg::item_t it);
        burst_q.delete();
        if (it.op == css_mrk_pkg::OP_END)
            end_of_text();
        else
            text_byte(it.byte_value);
        if (burst_q.size() > 0)
            burst_q[burst_q.size()-1].last = 1'b1;
        foreach (burst_q[i])
            marks_due.push_back(burst_q[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void add_item(logic op, logic [7:0] b);
        text_item_t t;
        t.it.op         = op;
        t.it.byte_value = b;
        t.drain         = drain_mark;
        drain_mark      = 1'b0;
        text_q.push_back(t);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        add_item(css_mrk_pkg::OP_TEXT, b);
    endfunction

    function automatic void add_end();
        add_item(css_mrk_pkg::OP_END, 8'($urandom_range(0, 255)));
    endfunction

    // Mostly letters, sometimes any byte at all
    function automatic void add_word();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            if ($urandom_range(0, 4) == 0)
                add_byte(8'($urandom_range(0, 255)));
            else
                add_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
        // truncated text now and then
        if ($urandom_range(0, 39) == 0)
            add_end();
    endfunction

    function automatic void add_comment();
        add_byte(css_mrk_pkg::CH_SLASH);
        add_byte(css_mrk_pkg::CH_STAR);
        add_word();
        repeat ($urandom_range(1, 3))
            add_byte(css_mrk_pkg::CH_STAR);
        add_byte(css_mrk_pkg::CH_SLASH);
    endfunction

    function automatic void add_string();
        logic [7:0] q;
        q = $urandom_range(0, 1) ? css_mrk_pkg::CH_QUOTE : css_mrk_pkg::CH_DQUOTE;
        add_byte(q);
        add_word();
        if ($urandom_range(0, 1) == 0)
        begin
            add_byte(css_mrk_pkg::CH_BSLASH);
            add_byte($urandom_range(0, 1) ? q : 8'($urandom_range(0, 255)));
        end
        add_byte(q);
    endfunction

    // A selector list with a block of declarations
    function automatic void add_rule();
        int n_decl;
        add_word();
        if ($urandom_range(0, 2) == 0)
        begin
            add_byte(css_mrk_pkg::CH_COMMA);
            add_word();
        end
        if ($urandom_range(0, 4) == 0)
            add_comment();
        add_byte(css_mrk_pkg::CH_LBRACE);
        n_decl = $urandom_range(0, 3);
        for (int d = 0; d < n_decl; d++)
        begin
            add_word();
            if ($urandom_range(0, 5) == 0)
                add_comment();
            add_byte(css_mrk_pkg::CH_COLON);
            add_word();
            if ($urandom_range(0, 2) == 0)
                add_string();
            if ($urandom_range(0, 5) == 0)
                add_comment();
            if ($urandom_range(0, 6) == 0)
            begin
                add_byte(css_mrk_pkg::CH_SLASH);
                add_word();
            end
            if (d < n_decl - 1 || $urandom_range(0, 1) == 0)
                add_byte(css_mrk_pkg::CH_SEMI);
        end
        add_byte(css_mrk_pkg::CH_RBRACE);
    endfunction

    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Item driver: changes at falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_taken)
                ;  // stalled, payload held
            else if (tx_gap > 0)
            begin
                item_valid <= 1'b0;
                tx_gap--;
            end
            else if (text_q.size() > 0 && !(text_q[0].drain && marks_due.size() > 0))
            begin
                item       <= text_q[0].it;
                item_valid <= 1'b1;
                void'(text_q.pop_front());
                tx_count++;
                if (tx_count % 32 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                tx_gap = draw_wait(tx_calm);
            end
            else
                item_valid <= 1'b0;
            item_taken = 1'b0;
        end
    end

    // Result stall: fresh wait drawn after each accepted result
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                rx_count++;
                if (rx_count % 32 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_gap = draw_wait(rx_calm);
            end
            if (rx_gap > 0)
            begin
                result_stall <= 1'b1;
                rx_gap--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample at rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        css_mrk_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                result_taken = 1'b1;
                if (marks_due.size() == 0)
                    report_mismatch("unexpected result", int'(result), 0);
                else
                begin
                    want = marks_due.pop_front();
                    if (result.kind !== want.kind)
                        report_mismatch("kind", int'(result.kind), int'(want.kind));
                    if (result.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(result.out_byte),
                                        int'(want.out_byte));
                    if (result.style !== want.style)
                        report_mismatch("style", int'(result.style), int'(want.style));
                    if (result.last !== want.last)
                        report_mismatch("last", int'(result.last), int'(want.last));
                end
            end
            if (item_valid && !item_stall)
            begin
                item_taken = 1'b1;
                scan_item(item);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int n_target;

        // directed: flush at start, extremes, every region transition
        add_end();
        add_byte(8'h00);
        add_byte(css_mrk_pkg::CH_COMMA);
        add_byte(8'hFF);
        add_byte(css_mrk_pkg::CH_SLASH);
        add_byte(css_mrk_pkg::CH_LBRACE);
        add_byte(8'h61);
        add_byte(css_mrk_pkg::CH_SLASH);
        add_byte(css_mrk_pkg::CH_STAR);
        add_byte(css_mrk_pkg::CH_STAR);
        add_byte(css_mrk_pkg::CH_STAR);
        add_byte(css_mrk_pkg::CH_SLASH);
        add_byte(css_mrk_pkg::CH_COLON);
        add_byte(css_mrk_pkg::CH_QUOTE);
        add_byte(css_mrk_pkg::CH_BSLASH);
        add_byte(css_mrk_pkg::CH_QUOTE);
        add_byte(css_mrk_pkg::CH_QUOTE);
        add_byte(css_mrk_pkg::CH_SLASH);
        add_byte(css_mrk_pkg::CH_SEMI);
        add_byte(css_mrk_pkg::CH_RBRACE);
        add_byte(css_mrk_pkg::CH_DQUOTE);
        add_byte(css_mrk_pkg::CH_BSLASH);
        add_end();
        add_byte(css_mrk_pkg::CH_SLASH);
        add_end();
        add_byte(css_mrk_pkg::CH_LBRACE);
        add_byte(css_mrk_pkg::CH_COLON);
        add_byte(css_mrk_pkg::CH_RBRACE);
        add_end();

        // random CSS-like text, with a full drain before it and midway
        n_target   = text_q.size() + RANDOM_ITEMS;
        drain_mark = 1'b1;
        while (text_q.size() < n_target)
        begin
            if (text_q.size() > n_target - RANDOM_ITEMS / 2 && text_q.size() < n_target - 120)
                drain_mark = 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else
                add_rule();
            if ($urandom_range(0, 5) == 0)
                add_end();
        end
        add_end();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_q.size() > 0 || item_valid)
            @(posedge clk);
        while (marks_due.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && marks_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
